/* rtl/core/jsu_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// jsu_pkg
// Types and constants shared by the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    // Most result words one input word can cause.
    localparam int MAX_RES = 7;
    localparam int RES_IDX_W = $clog2(MAX_RES);

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_U      = 8'h75;
    localparam logic [7:0] CH_SPACE  = 8'h20;

    // Upper six bits of high and low surrogates.
    localparam logic [5:0] SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0] SUR_LOW_TAG  = 6'b110111;
    localparam logic [20:0] SUPP_BASE   = 21'h10000;

    typedef enum logic [2:0] {
        MODE_NORMAL,
        MODE_ESC,
        MODE_HEX,
        MODE_HELD,
        MODE_HELD_BS,
        MODE_PAIR_HEX
    } t_mode;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_ERR  = 2'd2
    } t_kind;

    typedef enum logic [2:0] {
        ERR_UNTERM_STR = 3'd0,
        ERR_UNTERM_ESC = 3'd1,
        ERR_BAD_ESC    = 3'd2,
        ERR_BAD_HEX    = 3'd3,
        ERR_RAW_CTRL   = 3'd4
    } t_err;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_err       code;
    } t_res;

    typedef struct packed {
        logic [2:0]      len;
        logic [3:0][7:0] b;
    } t_utf;

endpackage

/* rtl/core/json_string_unescape_utf8_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top
// JSON string body unescaper that turns escapes into UTF-8 bytes.
// ----------------------------------------------------------------------------
// The slave channel takes one byte of a JSON string body per word, starting
// after the opening quote; tlast marks the last byte of the available text.
// The master channel gives one result word per handshake: a decoded UTF-8
// byte, an end marker for the closing quote, or an error with its code.
// tlast on the master side marks the final result caused by one input word.
// An input word that causes no result (a backslash, a leading hex digit) is simply
// absorbed.
// An input word that is accepted is held in the input register; once the
// result list is free, its results are computed and loaded into the result
// list, and the first result is offered on the master side from there.
// Throughput: one input word per cycle while each word gives at most one
// result and the receiver is ready. A word that gives several results holds
// the result list until the single master port has passed them all on; the
// input register still takes one more word meanwhile.
// Reset clears both stages and the decoder state, so the first byte after
// reset is read as a plain string body byte. When the receiver stalls, the
// current result stays on the master port and the input side fills and
// then drops tready.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // text_ends
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    output logic [1:0]  m_axis_tuser,   // [1:0] kind
    output logic        m_axis_tlast    // last
);

    // UTF-8 form of a code point, one to four bytes.
    function automatic t_utf enc_utf8(input logic [20:0] cp);
        t_utf u;
        u = '0;
        if (cp < 21'h80) begin
            u.len  = 3'd1;
            u.b[0] = cp[7:0];
        end else if (cp < 21'h800) begin
            u.len  = 3'd2;
            u.b[0] = {3'b110, cp[10:6]};
            u.b[1] = {2'b10, cp[5:0]};
        end else if (cp < 21'h10000) begin
            u.len  = 3'd3;
            u.b[0] = {4'b1110, cp[15:12]};
            u.b[1] = {2'b10, cp[11:6]};
            u.b[2] = {2'b10, cp[5:0]};
        end else begin
            u.len  = 3'd4;
            u.b[0] = {5'b11110, cp[20:18]};
            u.b[1] = {2'b10, cp[17:12]};
            u.b[2] = {2'b10, cp[11:6]};
            u.b[3] = {2'b10, cp[5:0]};
        end
        return u;
    endfunction

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_in_ends;

    // Decoder state.
    t_mode       r_mode, n_mode;
    logic [15:0] r_acc, n_acc;
    logic [1:0]  r_hcnt, n_hcnt;
    logic [15:0] r_held, n_held;

    // Result list.
    logic                 r_lv;
    t_res                 r_list [MAX_RES];
    logic [RES_IDX_W-1:0] r_lidx;
    logic [RES_IDX_W-1:0] r_lcnt;

    // Step results before the end-of-text check.
    t_mode       s_mode;
    logic [15:0] s_acc;
    logic [1:0]  s_hcnt;
    logic [15:0] s_held;
    logic        s_fin;
    logic        s_clear;

    // Byte classification.
    logic        ch_quote, ch_bslash, ch_ctrl, ch_u;
    logic        hex_ok;
    logic [3:0]  hex_d;
    logic [15:0] acc_new;
    logic        acc_high, acc_low, last_digit;
    logic [20:0] pair_cp;
    logic        esc_ok;
    logic [7:0]  esc_byte;
    t_res        body_res, esc_res;

    // Result list assembly.
    logic                 rel_a, b_single_v, b_utf_v, c_err, rel_c;
    t_res                 b_single;
    logic [20:0]          b_cp;
    t_err                 c_code;
    t_utf                 utf_b, sur_a, sur_c;
    t_res                 n_list [MAX_RES];
    logic [RES_IDX_W-1:0] n_lcnt;

    // Handshake control.
    logic pop, list_done, can_adv, adv;

    assign pop       = r_lv && m_axis_tready;
    assign list_done = pop && (r_lidx == r_lcnt - RES_IDX_W'(1));
    assign can_adv   = !r_lv || list_done;
    assign adv       = r_in_valid && can_adv;
    assign s_axis_tready = !r_in_valid || can_adv;

    // ------------------------------------------------------------------
    // Byte classification
    // ------------------------------------------------------------------
    assign ch_quote  = (r_in_byte == CH_QUOTE);
    assign ch_bslash = (r_in_byte == CH_BSLASH);
    assign ch_ctrl   = (r_in_byte < CH_SPACE);
    assign ch_u      = (r_in_byte == CH_U);

    always_comb begin
        hex_ok = 1'b1;
        hex_d  = r_in_byte[3:0];
        if (r_in_byte >= 8'h30 && r_in_byte <= 8'h39) begin
            hex_d = r_in_byte[3:0];
        end else if ((r_in_byte >= 8'h61 && r_in_byte <= 8'h66) ||
                     (r_in_byte >= 8'h41 && r_in_byte <= 8'h46)) begin
            hex_d = r_in_byte[3:0] + 4'd9;
        end else begin
            hex_ok = 1'b0;
        end
    end

    always_comb begin
        esc_ok   = 1'b1;
        esc_byte = r_in_byte;
        unique case (r_in_byte)
            8'h22:   esc_byte = 8'h22;
            8'h5C:   esc_byte = 8'h5C;
            8'h2F:   esc_byte = 8'h2F;
            8'h62:   esc_byte = 8'h08;
            8'h66:   esc_byte = 8'h0C;
            8'h6E:   esc_byte = 8'h0A;
            8'h72:   esc_byte = 8'h0D;
            8'h74:   esc_byte = 8'h09;
            default: esc_ok   = 1'b0;
        endcase
    end

    assign acc_new    = {r_acc[11:0], hex_d};
    assign acc_high   = (acc_new[15:10] == SUR_HIGH_TAG);
    assign acc_low    = (acc_new[15:10] == SUR_LOW_TAG);
    assign last_digit = (r_hcnt == 2'd3);
    assign pair_cp    = SUPP_BASE + {1'b0, r_held[9:0], acc_new[9:0]};

    always_comb begin
        if (ch_quote) begin
            body_res = '{data: 8'h00, kind: KIND_END, code: ERR_UNTERM_STR};
        end else if (ch_ctrl) begin
            body_res = '{data: 8'h00, kind: KIND_ERR, code: ERR_RAW_CTRL};
        end else begin
            body_res = '{data: r_in_byte, kind: KIND_DATA, code: ERR_UNTERM_STR};
        end
        if (esc_ok) begin
            esc_res = '{data: esc_byte, kind: KIND_DATA, code: ERR_UNTERM_STR};
        end else begin
            esc_res = '{data: 8'h00, kind: KIND_ERR, code: ERR_BAD_ESC};
        end
    end

    // ------------------------------------------------------------------
    // Next state
    // ------------------------------------------------------------------
    always_comb begin
        s_mode  = r_mode;
        s_acc   = r_acc;
        s_hcnt  = r_hcnt;
        s_held  = r_held;
        s_fin   = 1'b0;
        s_clear = 1'b0;
        unique case (r_mode)
            MODE_ESC: begin
                s_mode = MODE_NORMAL;
                if (ch_u) begin
                    s_mode = MODE_HEX;
                    s_acc  = '0;
                    s_hcnt = '0;
                end else if (!esc_ok) begin
                    s_clear = 1'b1;
                    s_fin   = 1'b1;
                end
            end
            MODE_HEX, MODE_PAIR_HEX: begin
                if (!hex_ok) begin
                    s_clear = 1'b1;
                    s_fin   = 1'b1;
                end else if (!last_digit) begin
                    s_acc  = acc_new;
                    s_hcnt = r_hcnt + 2'd1;
                end else begin
                    s_acc  = '0;
                    s_hcnt = '0;
                    if (r_mode == MODE_PAIR_HEX && acc_low) begin
                        s_held = '0;
                        s_mode = MODE_NORMAL;
                    end else if (acc_high) begin
                        s_held = acc_new;
                        s_mode = MODE_HELD;
                    end else begin
                        s_held = '0;
                        s_mode = MODE_NORMAL;
                    end
                end
            end
            MODE_HELD: begin
                if (ch_bslash) begin
                    s_mode = MODE_HELD_BS;
                end else begin
                    s_held = '0;
                    s_mode = MODE_NORMAL;
                    if (ch_quote || ch_ctrl) begin
                        s_clear = 1'b1;
                        s_fin   = 1'b1;
                    end
                end
            end
            MODE_HELD_BS: begin
                if (ch_u) begin
                    s_mode = MODE_PAIR_HEX;
                    s_acc  = '0;
                    s_hcnt = '0;
                end else begin
                    s_held = '0;
                    s_mode = MODE_NORMAL;
                    if (!esc_ok) begin
                        s_clear = 1'b1;
                        s_fin   = 1'b1;
                    end
                end
            end
            default: begin
                s_mode = MODE_NORMAL;
                if (ch_quote || ch_ctrl) begin
                    s_clear = 1'b1;
                    s_fin   = 1'b1;
                end else if (ch_bslash) begin
                    s_mode = MODE_ESC;
                end
            end
        endcase

        // End of text with the string still open closes it with an error.
        if (s_clear || (r_in_ends && !s_fin)) begin
            n_mode = MODE_NORMAL;
            n_acc  = '0;
            n_hcnt = '0;
            n_held = '0;
        end else begin
            n_mode = s_mode;
            n_acc  = s_acc;
            n_hcnt = s_hcnt;
            n_held = s_held;
        end
    end

    // ------------------------------------------------------------------
    // Results: released surrogate, main result, end-of-text error
    // ------------------------------------------------------------------
    always_comb begin
        rel_a      = 1'b0;
        b_single_v = 1'b0;
        b_single   = body_res;
        b_utf_v    = 1'b0;
        b_cp       = {5'd0, acc_new};
        unique case (r_mode)
            MODE_ESC: begin
                b_single_v = !ch_u;
                b_single   = esc_res;
            end
            MODE_HEX, MODE_PAIR_HEX: begin
                if (!hex_ok) begin
                    rel_a      = (r_mode == MODE_PAIR_HEX);
                    b_single_v = 1'b1;
                    b_single   = '{data: 8'h00, kind: KIND_ERR, code: ERR_BAD_HEX};
                end else if (last_digit) begin
                    if (r_mode == MODE_PAIR_HEX && acc_low) begin
                        b_utf_v = 1'b1;
                        b_cp    = pair_cp;
                    end else begin
                        rel_a   = (r_mode == MODE_PAIR_HEX);
                        b_utf_v = !acc_high;
                    end
                end
            end
            MODE_HELD: begin
                rel_a      = !ch_bslash;
                b_single_v = !ch_bslash;
            end
            MODE_HELD_BS: begin
                rel_a      = !ch_u;
                b_single_v = !ch_u;
                b_single   = esc_res;
            end
            default: begin
                b_single_v = !ch_bslash;
            end
        endcase

        c_err  = r_in_ends && !s_fin;
        rel_c  = c_err && (s_mode == MODE_HELD || s_mode == MODE_HELD_BS ||
                           s_mode == MODE_PAIR_HEX);
        unique case (s_mode)
            MODE_ESC, MODE_HELD_BS: c_code = ERR_UNTERM_ESC;
            MODE_HEX, MODE_PAIR_HEX: c_code = ERR_BAD_HEX;
            default:                c_code = ERR_UNTERM_STR;
        endcase
    end

    assign utf_b = enc_utf8(b_cp);
    assign sur_a = enc_utf8({5'd0, r_held});
    assign sur_c = enc_utf8({5'd0, s_held});

    // Packs the three segments into the list in order.
    always_comb begin
        logic [RES_IDX_W-1:0] k;
        k = '0;
        for (int i = 0; i < MAX_RES; i++) begin
            n_list[i] = '{data: 8'h00, kind: KIND_DATA, code: ERR_UNTERM_STR};
        end
        if (rel_a) begin
            for (int j = 0; j < 3; j++) begin
                n_list[k] = '{data: sur_a.b[j], kind: KIND_DATA, code: ERR_UNTERM_STR};
                k = k + RES_IDX_W'(1);
            end
        end
        if (b_single_v) begin
            n_list[k] = b_single;
            k = k + RES_IDX_W'(1);
        end
        if (b_utf_v) begin
            for (int j = 0; j < 4; j++) begin
                if (3'(j) < utf_b.len) begin
                    n_list[k] = '{data: utf_b.b[j], kind: KIND_DATA,
                                  code: ERR_UNTERM_STR};
                    k = k + RES_IDX_W'(1);
                end
            end
        end
        if (rel_c) begin
            for (int j = 0; j < 3; j++) begin
                n_list[k] = '{data: sur_c.b[j], kind: KIND_DATA, code: ERR_UNTERM_STR};
                k = k + RES_IDX_W'(1);
            end
        end
        if (c_err) begin
            n_list[k] = '{data: 8'h00, kind: KIND_ERR, code: c_code};
            k = k + RES_IDX_W'(1);
        end
        n_lcnt = k;
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_lv       <= 1'b0;
            r_lidx     <= '0;
            r_lcnt     <= '0;
            r_mode     <= MODE_NORMAL;
            r_acc      <= '0;
            r_hcnt     <= '0;
            r_held     <= '0;
        end else begin
            if (s_axis_tready) begin
                r_in_valid <= s_axis_tvalid;
            end
            if (adv) begin
                r_mode <= n_mode;
                r_acc  <= n_acc;
                r_hcnt <= n_hcnt;
                r_held <= n_held;
            end
            if (adv && n_lcnt != '0) begin
                r_lv   <= 1'b1;
                r_lidx <= '0;
                r_lcnt <= n_lcnt;
            end else if (list_done) begin
                r_lv <= 1'b0;
            end else if (pop) begin
                r_lidx <= r_lidx + RES_IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte <= s_axis_tdata;
            r_in_ends <= s_axis_tlast;
        end
        if (adv && n_lcnt != '0) begin
            r_list <= n_list;
        end
    end

    // ------------------------------------------------------------------
    // Master side
    // ------------------------------------------------------------------
    t_res cur;
    assign cur           = r_list[r_lidx];
    assign m_axis_tvalid = r_lv;
    assign m_axis_tdata  = {5'd0, cur.code, cur.data};
    assign m_axis_tuser  = cur.kind;
    assign m_axis_tlast  = (r_lidx == r_lcnt - RES_IDX_W'(1));

`ifndef ASSERT_OFF
    a_idx_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_lv |-> (r_lcnt != '0 && r_lidx < r_lcnt))
        else $error("result index outside the loaded list");

    a_list_restarts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=>
            (!m_axis_tvalid || r_lidx == '0))
        else $error("new result list does not start at its first entry");

    a_held_is_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_mode == MODE_HELD || r_mode == MODE_HELD_BS || r_mode == MODE_PAIR_HEX)
            |-> (r_held[15:10] == SUR_HIGH_TAG))
        else $error("held value is not a high surrogate");

    a_stage_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !can_adv) |=> r_in_valid)
        else $error("waiting input word was lost");
`endif

endmodule

/* tb/sv/json_string_unescape_utf8_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_checker
// Watches both stream channels of the JSON string unescaper and checks every
// result word against an independent decode of the accepted text bytes.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_checker
    import jsu_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] text_byte
    input  logic        s_axis_tlast,   // text_ends
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [15:0] m_axis_tdata,   // [7:0] out_byte, [10:8] error_code, rest zero
    input  logic [1:0]  m_axis_tuser,   // [1:0] kind
    input  logic        m_axis_tlast,   // last
    output int          o_fail_count,
    output int          o_pending,
    output int          o_checked
);

    // Words that are not errors carry a zero code.
    localparam t_err NO_CODE = ERR_UNTERM_STR;
    localparam int   PRINT_CAP = 40;

    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        t_err       code;
        logic       last;
    } t_res_word;

    t_mode       dec_mode;
    logic [15:0] hex_acc;
    logic [1:0]  hex_cnt;
    logic [15:0] held_sur;
    bit          string_done;

    t_res_word   step_words[$];
    t_res_word   decoded_q[$];
    int          mismatch_count = 0;
    int          checked_count = 0;

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
        o_checked    = 0;
    end

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_CAP) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    task automatic emit(input logic [7:0] b, input t_kind k, input t_err c);
        t_res_word w;
        if (step_words.size() < MAX_RES) begin
            w.data = b;
            w.kind = k;
            w.code = c;
            w.last = 1'b0;
            step_words.insert(step_words.size(), w);
        end
    endtask

    task automatic emit_utf8(input logic [20:0] cp);
        if (cp < 21'h80) begin
            emit(cp[7:0], KIND_DATA, NO_CODE);
        end else if (cp < 21'h800) begin
            emit({3'b110, cp[10:6]}, KIND_DATA, NO_CODE);
            emit({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
        end else if (cp < 21'h10000) begin
            emit({4'b1110, cp[15:12]}, KIND_DATA, NO_CODE);
            emit({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
            emit({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
        end else begin
            emit({5'b11110, cp[20:18]}, KIND_DATA, NO_CODE);
            emit({2'b10, cp[17:12]}, KIND_DATA, NO_CODE);
            emit({2'b10, cp[11:6]}, KIND_DATA, NO_CODE);
            emit({2'b10, cp[5:0]}, KIND_DATA, NO_CODE);
        end
    endtask

    task automatic clear_decoder();
        dec_mode = MODE_NORMAL;
        hex_acc  = 16'h0;
        hex_cnt  = 2'd0;
        held_sur = 16'h0;
    endtask

    task automatic flag_error(input t_err c);
        emit(8'h00, KIND_ERR, c);
        clear_decoder();
        string_done = 1'b1;
    endtask

    task automatic release_held();
        emit_utf8({5'd0, held_sur});
        held_sur = 16'h0;
        dec_mode = MODE_NORMAL;
    endtask

    // A high surrogate is kept back in case a low one follows.
    task automatic settle_code_point(input logic [15:0] cp);
        if (cp >= 16'hD800 && cp <= 16'hDBFF) begin
            held_sur = cp;
            dec_mode = MODE_HELD;
        end else begin
            emit_utf8({5'd0, cp});
            dec_mode = MODE_NORMAL;
        end
    endtask

    task automatic take_body(input logic [7:0] c);
        if (c == CH_QUOTE) begin
            emit(8'h00, KIND_END, NO_CODE);
            clear_decoder();
            string_done = 1'b1;
        end else if (c == CH_BSLASH) begin
            dec_mode = MODE_ESC;
        end else if (c < CH_SPACE) begin
            flag_error(ERR_RAW_CTRL);
        end else begin
            emit(c, KIND_DATA, NO_CODE);
        end
    endtask

    task automatic take_escape(input logic [7:0] c);
        dec_mode = MODE_NORMAL;
        case (c)
            CH_QUOTE:  emit(CH_QUOTE, KIND_DATA, NO_CODE);
            CH_BSLASH: emit(CH_BSLASH, KIND_DATA, NO_CODE);
            "/":       emit("/", KIND_DATA, NO_CODE);
            "b":       emit(8'h08, KIND_DATA, NO_CODE);
            "f":       emit(8'h0C, KIND_DATA, NO_CODE);
            "n":       emit(8'h0A, KIND_DATA, NO_CODE);
            "r":       emit(8'h0D, KIND_DATA, NO_CODE);
            "t":       emit(8'h09, KIND_DATA, NO_CODE);
            CH_U: begin
                dec_mode = MODE_HEX;
                hex_acc  = 16'h0;
                hex_cnt  = 2'd0;
            end
            default:   flag_error(ERR_BAD_ESC);
        endcase
    endtask

    function automatic int hex_digit(input logic [7:0] c);
        if (c >= "0" && c <= "9") return int'(c - "0");
        if (c >= "a" && c <= "f") return int'(c - "a") + 10;
        if (c >= "A" && c <= "F") return int'(c - "A") + 10;
        return -1;
    endfunction

    // Decodes one text byte and appends the words it causes to decoded_q.
    task automatic unescape_byte(input logic [7:0] c, input logic ends);
        int        d;
        t_res_word w;
        step_words.delete();
        string_done = 1'b0;
        case (dec_mode)
            MODE_ESC: take_escape(c);
            MODE_HEX, MODE_PAIR_HEX: begin
                d = hex_digit(c);
                if (d < 0) begin
                    if (dec_mode == MODE_PAIR_HEX) release_held();
                    flag_error(ERR_BAD_HEX);
                end else begin
                    hex_acc = {hex_acc[11:0], d[3:0]};
                    if (hex_cnt != 2'd3) begin
                        hex_cnt++;
                    end else begin
                        hex_cnt = 2'd0;
                        if (dec_mode == MODE_HEX) begin
                            settle_code_point(hex_acc);
                        end else if (hex_acc >= 16'hDC00 && hex_acc <= 16'hDFFF) begin
                            emit_utf8(21'h10000 + {1'b0, held_sur[9:0], hex_acc[9:0]});
                            held_sur = 16'h0;
                            dec_mode = MODE_NORMAL;
                        end else begin
                            release_held();
                            settle_code_point(hex_acc);
                        end
                        hex_acc = 16'h0;
                    end
                end
            end
            MODE_HELD: begin
                if (c == CH_BSLASH) begin
                    dec_mode = MODE_HELD_BS;
                end else begin
                    release_held();
                    take_body(c);
                end
            end
            MODE_HELD_BS: begin
                if (c == CH_U) begin
                    dec_mode = MODE_PAIR_HEX;
                    hex_acc  = 16'h0;
                    hex_cnt  = 2'd0;
                end else begin
                    release_held();
                    take_escape(c);
                end
            end
            default: begin
                dec_mode = MODE_NORMAL;
                take_body(c);
            end
        endcase

        if (ends && !string_done) begin
            case (dec_mode)
                MODE_ESC: flag_error(ERR_UNTERM_ESC);
                MODE_HEX: flag_error(ERR_BAD_HEX);
                MODE_HELD: begin
                    release_held();
                    flag_error(ERR_UNTERM_STR);
                end
                MODE_HELD_BS: begin
                    release_held();
                    flag_error(ERR_UNTERM_ESC);
                end
                MODE_PAIR_HEX: begin
                    release_held();
                    flag_error(ERR_BAD_HEX);
                end
                default: flag_error(ERR_UNTERM_STR);
            endcase
        end

        if (step_words.size() > 0) begin
            w = step_words[step_words.size() - 1];
            w.last = 1'b1;
            step_words[step_words.size() - 1] = w;
        end
        foreach (step_words[i]) decoded_q.insert(decoded_q.size(), step_words[i]);
    endtask

    task automatic check_word();
        t_res_word want;
        if (decoded_q.size() == 0) begin
            report_mismatch($sformatf("result word with nothing pending: data %h kind %0d",
                                      m_axis_tdata, m_axis_tuser));
        end else begin
            want = decoded_q.pop_front();
            if (m_axis_tdata[7:0] !== want.data)
                report_mismatch($sformatf("word %0d out_byte %h, expected %h",
                                          checked_count, m_axis_tdata[7:0], want.data));
            if (m_axis_tuser !== want.kind)
                report_mismatch($sformatf("word %0d kind %0d, expected %0d",
                                          checked_count, m_axis_tuser, want.kind));
            if (m_axis_tdata[10:8] !== want.code)
                report_mismatch($sformatf("word %0d error_code %0d, expected %0d",
                                          checked_count, m_axis_tdata[10:8], want.code));
            if (m_axis_tlast !== want.last)
                report_mismatch($sformatf("word %0d last %b, expected %b",
                                          checked_count, m_axis_tlast, want.last));
            if (m_axis_tdata[15:11] !== 5'd0)
                report_mismatch($sformatf("word %0d padding bits %b not zero",
                                          checked_count, m_axis_tdata[15:11]));
        end
        checked_count++;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            clear_decoder();
            decoded_q.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) unescape_byte(s_axis_tdata, s_axis_tlast);
            if (m_axis_tvalid && m_axis_tready) check_word();
        end
        o_fail_count <= mismatch_count;
        o_pending    <= decoded_q.size();
        o_checked    <= checked_count;
    end

endmodule

/* tb/sv/json_string_unescape_utf8_top_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// json_string_unescape_utf8_top_test
// Stimulus and verdict for the JSON string unescaper.
// ----------------------------------------------------------------------------
// A short directed run covers control bytes, pass-through bytes at both ends
// of the range, a closing quote, a simple escape, a surrogate pair, a bad
// escape and text that ends inside a string. Random strings follow, built
// mostly from well-formed pieces (plain bytes, escapes, \u values of every
// UTF-8 length, surrogate pairs and held high surrogates with each kind of
// follower) mixed with noise, bad escapes, bad hex and text cut short. The
// checker beside the block predicts and compares every result word; this
// module only drives the channels and reports the outcome.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8_top_test;
    import jsu_pkg::*;

    localparam int RANDOM_BYTES   = 250;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int CYCLE_LIMIT    = 100000;
    localparam int DRAIN_CYCLES   = 16;

    // How the receiver treats m_axis_tready in the current part of the run.
    typedef enum int {
        RX_RANDOM,
        RX_HOLD,
        RX_ALWAYS
    } t_rx_plan;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = 8'h00;   // [7:0] text_byte
    logic        s_axis_tlast = 1'b0;    // text_ends
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;           // [7:0] out_byte, [10:8] error_code, rest zero
    logic [1:0]  m_axis_tuser;           // [1:0] kind
    logic        m_axis_tlast;           // last

    int          fail_count;
    int          words_pending;
    int          words_checked;

    t_rx_plan    rx_plan = RX_RANDOM;
    bit          tx_gaps = 1'b1;
    int          bytes_sent = 0;

    // Text waiting to be sent: bit 8 carries text_ends, bits 7:0 the byte.
    logic [8:0]  text_q[$];

    logic [7:0]  esc_letters [8] = '{CH_QUOTE, CH_BSLASH, "/", "b", "f", "n", "r", "t"};

    always #6 i_clk = ~i_clk;

    json_string_unescape_utf8_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    json_string_unescape_utf8_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .o_fail_count  (fail_count),
        .o_pending     (words_pending),
        .o_checked     (words_checked)
    );

    // ------------------------------------------------------------------
    // Text building helpers.
    // ------------------------------------------------------------------
    task automatic add_byte(input logic [7:0] b);
        text_q.insert(text_q.size(), {1'b0, b});
    endtask

    // Hex letters come in either case, picked per digit.
    function automatic logic [7:0] hex_char(input logic [3:0] n);
        if (n < 4'd10) return "0" + n;
        return ($urandom_range(0, 1) ? "a" : "A") + (n - 4'd10);
    endfunction

    task automatic add_u(input logic [15:0] v);
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        for (int i = 3; i >= 0; i--) add_byte(hex_char(v[4*i +: 4]));
    endtask

    function automatic logic [7:0] pick_non_hex();
        logic [7:0] b;
        do b = 8'($urandom_range(0, 255));
        while ((b >= "0" && b <= "9") || (b >= "a" && b <= "f") || (b >= "A" && b <= "F"));
        return b;
    endfunction

    // Any byte that is neither a simple escape letter nor 'u'.
    function automatic logic [7:0] pick_bad_escape();
        logic [7:0] b;
        bit         known;
        do begin
            b = 8'($urandom_range(0, 255));
            known = (b == CH_U);
            foreach (esc_letters[i]) if (esc_letters[i] == b) known = 1'b1;
        end while (known);
        return b;
    endfunction

    function automatic logic [15:0] pick_high();
        return 16'($urandom_range(16'hD800, 16'hDBFF));
    endfunction

    function automatic logic [15:0] pick_low();
        return 16'($urandom_range(16'hDC00, 16'hDFFF));
    endfunction

    // Values spread over one, two and three byte encodings, lone low
    // surrogates, and the whole range.
    function automatic logic [15:0] pick_u_value();
        case ($urandom_range(0, 5))
            0:       return 16'($urandom_range(16'h0000, 16'h007F));
            1:       return 16'($urandom_range(16'h0080, 16'h07FF));
            2:       return 16'($urandom_range(16'h0800, 16'hD7FF));
            3:       return 16'($urandom_range(16'hE000, 16'hFFFF));
            4:       return pick_low();
            default: return 16'($urandom_range(16'h0000, 16'hFFFF));
        endcase
    endfunction

    // A \u with zero to three good digits and then a bad one.
    task automatic add_bad_u();
        add_byte(CH_BSLASH);
        add_byte(CH_U);
        repeat ($urandom_range(0, 3)) add_byte(hex_char(4'($urandom_range(0, 15))));
        add_byte(pick_non_hex());
    endtask

    // Appends one piece of a string body, mostly well formed.
    task automatic add_random_token();
        int         pick;
        int         first;
        int         cut;
        logic [7:0] b;
        logic [8:0] w;
        pick  = $urandom_range(0, 99);
        first = text_q.size();
        if (pick < 35) begin
            do b = 8'($urandom_range(8'h20, 8'hFF));
            while (b == CH_QUOTE || b == CH_BSLASH);
            add_byte(b);
        end else if (pick < 47) begin
            add_byte(CH_BSLASH);
            add_byte(esc_letters[$urandom_range(0, 7)]);
        end else if (pick < 59) begin
            add_u(pick_u_value());
        end else if (pick < 67) begin
            add_u(pick_high());
            add_u(pick_low());
        end else if (pick < 77) begin
            // A high surrogate, then something that may or may not pair with it.
            add_u(pick_high());
            case ($urandom_range(0, 4))
                0: begin
                    do b = 8'($urandom_range(0, 255));
                    while (b == CH_BSLASH);
                    add_byte(b);
                end
                1: begin
                    add_byte(CH_BSLASH);
                    add_byte($urandom_range(0, 1) ? esc_letters[$urandom_range(0, 7)]
                                                  : pick_bad_escape());
                end
                2: add_u($urandom_range(0, 1) ? pick_high() : pick_u_value());
                3: add_bad_u();
                default: ;
            endcase
        end else if (pick < 80) begin
            add_byte(CH_BSLASH);
            add_byte(pick_bad_escape());
        end else if (pick < 83) begin
            add_bad_u();
        end else if (pick < 86) begin
            add_byte(8'($urandom_range(8'h00, 8'h1F)));
        end else if (pick < 94) begin
            add_byte(CH_QUOTE);
        end else begin
            add_byte(8'($urandom_range(0, 255)));
        end

        // Cut some escape sequences short so the text ends inside every mode.
        if (pick >= 47 && pick < 83 && $urandom_range(0, 99) < 15) begin
            cut = $urandom_range(first, text_q.size() - 1);
            w = text_q[cut];
            w[8] = 1'b1;
            text_q[cut] = w;
        end
    endtask

    // ------------------------------------------------------------------
    // Sender: one word per handshake, with random gaps when allowed.
    // ------------------------------------------------------------------
    task automatic send_text_byte(input logic [7:0] b, input logic ends);
        if (tx_gaps) begin
            while ($urandom_range(0, 99) < 19) begin
                s_axis_tvalid <= 1'b0;
                @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= ends;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        bytes_sent++;
    endtask

    // Sends the queued text; a few bytes also end the text at random.
    task automatic send_text();
        logic [8:0] w;
        while (text_q.size() > 0) begin
            w = text_q.pop_front();
            send_text_byte(w[7:0], w[8] | ($urandom_range(0, 99) < 3));
        end
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, one long hold-off that lets the block fill
    // and push back on the sender, and a stretch that is always ready.
    // ------------------------------------------------------------------
    initial begin
        bit hold_done;
        int held;
        hold_done = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_plan == RX_HOLD && !hold_done) begin
                m_axis_tready <= 1'b0;
                for (held = 0; held < RX_HOLD_CYCLES; held++) @(posedge i_clk);
                hold_done = 1'b1;
            end else if (rx_plan == RX_ALWAYS) begin
                m_axis_tready <= 1'b1;
            end else begin
                m_axis_tready <= ($urandom_range(0, 99) >= 19);
            end
        end
    end

    // Watchdog: a run that takes this long has hung somewhere.
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles with %0d result words pending",
                 CYCLE_LIMIT, words_pending);
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Main sequence.
    // ------------------------------------------------------------------
    initial begin
        int random_start;
        int n;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part. Control bytes at both ends of their range are
        // errors; 0xFF, 0x7F and space pass through; then a closing quote.
        add_byte(8'h00);
        add_byte(8'h1F);
        add_byte(8'hFF);
        add_byte(8'h7F);
        add_byte(CH_SPACE);
        add_byte(CH_QUOTE);
        // A simple escape, then a surrogate pair that becomes four bytes.
        add_byte(CH_BSLASH);
        add_byte("n");
        add_u(16'hD83D);
        add_u(16'hDE00);
        // An unknown escape letter, then text that ends in the body.
        add_byte(CH_BSLASH);
        add_byte("q");
        text_q.insert(text_q.size(), {1'b1, "A"});
        send_text();

        // Random strings, with the hold-off and the ready stretch in the middle.
        random_start = bytes_sent;
        while (bytes_sent - random_start < RANDOM_BYTES) begin
            n = bytes_sent - random_start;
            if (n >= 100 && n < 140) begin
                rx_plan <= RX_HOLD;
                tx_gaps = 1'b0;
            end else if (n >= 140 && n < 180) begin
                rx_plan <= RX_ALWAYS;
                tx_gaps = 1'b0;
            end else begin
                rx_plan <= RX_RANDOM;
                tx_gaps = 1'b1;
            end
            add_random_token();
            send_text();
        end
        s_axis_tvalid <= 1'b0;
        s_axis_tlast  <= 1'b0;

        // Let the checker take in the last byte, wait for every expected
        // word, then watch a little longer for words that should not be there.
        @(posedge i_clk);
        while (words_pending != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Covered %0d text bytes: directed escapes and surrogates, then random",
                 bytes_sent);
        $display("strings with noise and cut-off text; %0d result words compared.",
                 words_checked);
        if (fail_count == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
